@@ rtl/tlpte_pkg.sv @@
// Shared types and constants of the two-level page table engine.
package tlpte_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int TBL_AW        = 10;
	localparam int OFF_W         = 12;
	localparam int FRAME_W       = 20;
	localparam int VDIR_W        = 10;
	localparam int FLAG_USER     = 2;

	typedef enum logic [1:0] {
		CMD_MAP   = 2'd0,
		CMD_UNMAP = 2'd1,
		CMD_XLATE = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ALREADY    = 2'd1,
		ST_NOT_MAPPED = 2'd2,
		ST_RANGE      = 2'd3
	} status_t;

	typedef enum logic {
		CLR_SWEEP = 1'b0,
		CLR_DONE  = 1'b1
	} clr_state_t;

	typedef struct packed {
		logic dir_we;
		logic page_we;
	} store_wr_t;

endpackage

@@ rtl/two_level_page_table_engine.sv @@
// Top level of the two-level page table engine: command stage and result register.
// Usage:
//   Commands enter on cmd_valid/cmd_ready with command, virt_addr, frame_addr and
//   page_flags; one result per command leaves on rsp_valid/rsp_ready with status
//   and translated_addr. A transfer happens when valid and ready are both high.
//   When a command is taken, its directory and page entries are read from the
//   synchronous memories; once the output register is free, the entry is updated
//   in place where the command calls for it and the result is loaded into the
//   output register. The stage holds one command at a time, so a new command is
//   not taken until the last one has had its memory read and its write-back.
//   After reset both memories are swept to zero, one entry per cycle, and
//   cmd_ready stays low until the sweep is done.
//   While rsp_ready is low the result holds in the output register, and the next
//   command may be taken and read; it waits in its stage until the register frees.
module two_level_page_table_engine #(
	parameter int DIR_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  command,
	input  logic [31:0] virt_addr,
	input  logic [31:0] frame_addr,
	input  logic [11:0] page_flags,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [31:0] translated_addr
);

	localparam int DIR_AW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;

	logic                          init_done;
	logic                          accept;
	logic                          complete;
	logic                          valid_s1;
	tlpte_pkg::cmd_t               cmd_s1;
	logic                          range_s1;
	logic [DIR_AW-1:0]             dir_s1;
	logic [tlpte_pkg::TBL_AW-1:0]  tbl_s1;
	logic [tlpte_pkg::OFF_W-1:0]   off_s1;
	logic [tlpte_pkg::FRAME_W-1:0] frame_s1;
	logic [11:0]                   flags_s1;

	logic [DIR_AW-1:0]             dir_idx;
	logic [tlpte_pkg::TBL_AW-1:0]  tbl_idx;
	logic [1:0]                    dir_rdata;
	logic [31:0]                   page_rdata;
	logic [1:0]                    dir_wdata;
	logic [31:0]                   page_wdata;
	tlpte_pkg::store_wr_t          wr;

	logic                          dir_present;
	logic                          pte_hit;
	tlpte_pkg::status_t            status_nxt;
	logic [31:0]                   result_nxt;
	logic                          in_range;

	assign cmd_ready = init_done & ~valid_s1;
	assign accept    = cmd_valid & cmd_ready;
	assign complete  = valid_s1 & (~rsp_valid | rsp_ready);
	assign in_range  = ({1'b0, virt_addr[31:22]} < 11'(DIR_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (complete) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= tlpte_pkg::cmd_t'(command);
			range_s1 <= ~in_range;
			dir_s1   <= virt_addr[22 +: DIR_AW];
			tbl_s1   <= virt_addr[21:12];
			off_s1   <= virt_addr[11:0];
			frame_s1 <= frame_addr[31:12];
			flags_s1 <= page_flags;
		end
	end

	assign dir_idx = valid_s1 ? dir_s1 : virt_addr[22 +: DIR_AW];
	assign tbl_idx = valid_s1 ? tbl_s1 : virt_addr[21:12];

	tlpte_store #(
		.DIR_ENTRIES(DIR_ENTRIES),
		.DIR_AW     (DIR_AW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.dir_idx   (dir_idx),
		.tbl_idx   (tbl_idx),
		.wr        (wr),
		.dir_wdata (dir_wdata),
		.page_wdata(page_wdata),
		.dir_rdata (dir_rdata),
		.page_rdata(page_rdata),
		.init_done (init_done)
	);

	assign dir_present = dir_rdata[0];
	assign pte_hit     = dir_present & page_rdata[0];

	always_comb begin
		status_nxt = tlpte_pkg::ST_OK;
		result_nxt = 32'h0;
		wr         = '0;
		dir_wdata  = {dir_rdata[1] | flags_s1[tlpte_pkg::FLAG_USER], 1'b1};
		page_wdata = {frame_s1, flags_s1 | 12'h001};
		if (cmd_s1 == tlpte_pkg::CMD_NOP) begin
			status_nxt = tlpte_pkg::ST_OK;
		end else if (range_s1) begin
			status_nxt = tlpte_pkg::ST_RANGE;
		end else begin
			case (cmd_s1)
				tlpte_pkg::CMD_MAP: begin
					if (pte_hit) begin
						status_nxt = tlpte_pkg::ST_ALREADY;
					end else begin
						wr.dir_we  = complete;
						wr.page_we = complete;
					end
				end
				tlpte_pkg::CMD_UNMAP: begin
					page_wdata = 32'h0;
					if (pte_hit) begin
						wr.page_we = complete;
					end else begin
						status_nxt = tlpte_pkg::ST_NOT_MAPPED;
					end
				end
				tlpte_pkg::CMD_XLATE: begin
					if (pte_hit) begin
						result_nxt = {page_rdata[31:12], off_s1};
					end else begin
						status_nxt = tlpte_pkg::ST_NOT_MAPPED;
					end
				end
				default: status_nxt = tlpte_pkg::ST_OK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (complete) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			status          <= status_nxt;
			translated_addr <= result_nxt;
		end
	end

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted command did not enter the stage");

	a_write_only_on_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.dir_we || wr.page_we) |-> complete)
		else $error("memory write outside command completion");

	a_no_write_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && range_s1) |-> (!wr.dir_we && !wr.page_we))
		else $error("write for out-of-range directory index");

	a_addr_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && translated_addr != 32'h0) |-> (status == tlpte_pkg::ST_OK))
		else $error("nonzero address with error status");

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> !accept)
		else $error("command taken during clearing sweep");

endmodule

@@ rtl/tlpte_store.sv @@
// Directory and page entry memories with the clearing sweep after reset.
module tlpte_store #(
	parameter int DIR_ENTRIES = 64,
	parameter int DIR_AW      = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [DIR_AW-1:0]             dir_idx,
	input  logic [tlpte_pkg::TBL_AW-1:0]  tbl_idx,
	input  tlpte_pkg::store_wr_t          wr,
	input  logic [1:0]                    dir_wdata,
	input  logic [31:0]                   page_wdata,
	output logic [1:0]                    dir_rdata,
	output logic [31:0]                   page_rdata,
	output logic                          init_done
);

	localparam int PAGE_AW    = DIR_AW + tlpte_pkg::TBL_AW;
	localparam int PAGE_DEPTH = DIR_ENTRIES * tlpte_pkg::TABLE_ENTRIES;

	logic [1:0]  dir_mem  [DIR_ENTRIES];
	logic [31:0] page_mem [PAGE_DEPTH];

	tlpte_pkg::clr_state_t state_q, state_nxt;
	logic [PAGE_AW-1:0]    clr_q;
	logic                  sweeping;
	logic                  last_clr;

	logic [DIR_AW-1:0]  dir_waddr;
	logic [PAGE_AW-1:0] page_waddr;
	logic [PAGE_AW-1:0] page_raddr;
	logic               dir_we;
	logic               page_we;
	logic [1:0]         dir_wd;
	logic [31:0]        page_wd;

	assign last_clr = (clr_q == PAGE_AW'(PAGE_DEPTH - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tlpte_pkg::CLR_SWEEP: begin
				if (last_clr) state_nxt = tlpte_pkg::CLR_DONE;
			end
			tlpte_pkg::CLR_DONE: state_nxt = tlpte_pkg::CLR_DONE;
			default: state_nxt = tlpte_pkg::CLR_SWEEP;
		endcase
	end

	always_comb begin
		sweeping  = 1'b0;
		init_done = 1'b0;
		unique case (state_q)
			tlpte_pkg::CLR_SWEEP: sweeping = 1'b1;
			tlpte_pkg::CLR_DONE:  init_done = 1'b1;
			default: sweeping = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlpte_pkg::CLR_SWEEP;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (sweeping) clr_q <= clr_q + PAGE_AW'(1);
		end
	end

	assign page_raddr = {dir_idx, tbl_idx};
	assign dir_waddr  = sweeping ? clr_q[PAGE_AW-1:tlpte_pkg::TBL_AW] : dir_idx;
	assign page_waddr = sweeping ? clr_q : page_raddr;
	assign dir_we     = sweeping | wr.dir_we;
	assign page_we    = sweeping | wr.page_we;
	assign dir_wd     = sweeping ? 2'b00 : dir_wdata;
	assign page_wd    = sweeping ? 32'h0 : page_wdata;

	always_ff @(posedge clk) begin
		if (dir_we) dir_mem[dir_waddr] <= dir_wd;
		dir_rdata <= dir_mem[dir_idx];
	end

	always_ff @(posedge clk) begin
		if (page_we) page_mem[page_waddr] <= page_wd;
		page_rdata <= page_mem[page_raddr];
	end

endmodule

@@ test/page_walk_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the page table engine: tracks the page store and compares every transfer.
module page_walk_checker #(
	parameter int DIR_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_ready,
	input  logic [1:0]  command,
	input  logic [31:0] virt_addr,
	input  logic [31:0] frame_addr,
	input  logic [11:0] page_flags,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic [1:0]  status,
	input  logic [31:0] translated_addr,
	output int          mismatches,
	output int          in_flight
);

	localparam int DIR_AW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;

	typedef struct packed {
		tlpte_pkg::status_t st;
		logic [31:0]        addr;
	} walk_result_t;

	walk_result_t result_q[$];
	bit [1:0]     dir_bits [DIR_ENTRIES];
	bit [31:0]    pte_store [DIR_ENTRIES * tlpte_pkg::TABLE_ENTRIES];
	int           fail_count = 0;

	function automatic walk_result_t walk_and_update(tlpte_pkg::cmd_t cmd, logic [31:0] va,
		logic [31:0] fa, logic [11:0] fl);
		logic [9:0]                          di;
		logic [9:0]                          ti;
		logic [DIR_AW-1:0]                   ds;
		logic [DIR_AW+tlpte_pkg::TBL_AW-1:0] idx;
		logic                                pte_hit;
		walk_result_t                        r;
		r.st   = tlpte_pkg::ST_OK;
		r.addr = '0;
		di     = va[31:22];
		ti     = va[21:12];
		ds     = va[22 +: DIR_AW];
		if (cmd == tlpte_pkg::CMD_NOP)
			return r;
		if (int'(di) >= DIR_ENTRIES) begin
			r.st = tlpte_pkg::ST_RANGE;
			return r;
		end
		idx     = {ds, ti};
		pte_hit = dir_bits[ds][0] && pte_store[idx][0];
		case (cmd)
			tlpte_pkg::CMD_MAP: begin
				if (pte_hit) begin
					r.st = tlpte_pkg::ST_ALREADY;
				end else begin
					dir_bits[ds][0] = 1'b1;
					if (fl[tlpte_pkg::FLAG_USER])
						dir_bits[ds][1] = 1'b1;
					pte_store[idx] = {fa[31:12], fl} | 32'd1;
				end
			end
			tlpte_pkg::CMD_UNMAP: begin
				if (pte_hit)
					pte_store[idx] = '0;
				else
					r.st = tlpte_pkg::ST_NOT_MAPPED;
			end
			default: begin
				if (pte_hit)
					r.addr = {pte_store[idx][31:12], va[11:0]};
				else
					r.st = tlpte_pkg::ST_NOT_MAPPED;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		walk_result_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (result_q.size() == 0) begin
					$error("status: unexpected transfer, got %0d addr %h", status, translated_addr);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
					if (translated_addr !== want.addr) begin
						$error("translated_addr: expected %h, got %h", want.addr, translated_addr);
						fail_count++;
					end
				end
			end
			if (cmd_valid && cmd_ready)
				result_q.push_back(walk_and_update(tlpte_pkg::cmd_t'(command), virt_addr,
					frame_addr, page_flags));
		end
		mismatches <= fail_count;
		in_flight  <= result_q.size();
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the page table engine: clock, reset, command stimulus and verdict.
module tb_top;

	localparam int DIR_ENTRIES    = 64;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int POOL_SIZE      = 32;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	logic [1:0]  command;
	logic [31:0] virt_addr;
	logic [31:0] frame_addr;
	logic [11:0] page_flags;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [1:0]  status;
	logic [31:0] translated_addr;

	int          mismatches;
	int          in_flight;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	bit          hold_req = 0;
	int          idle_cycles = 0;
	logic [31:0] page_pool [POOL_SIZE];
	int          phase_tx [4] = '{0, 85, 0, 22};
	int          phase_rx [4] = '{0, 0, 85, 22};
	int          phase_len [4] = '{450, 350, 350, 450};

	two_level_page_table_engine #(
		.DIR_ENTRIES(DIR_ENTRIES)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.command        (command),
		.virt_addr      (virt_addr),
		.frame_addr     (frame_addr),
		.page_flags     (page_flags),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.status         (status),
		.translated_addr(translated_addr)
	);

	page_walk_checker #(
		.DIR_ENTRIES(DIR_ENTRIES)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.command        (command),
		.virt_addr      (virt_addr),
		.frame_addr     (frame_addr),
		.page_flags     (page_flags),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.status         (status),
		.translated_addr(translated_addr),
		.mismatches     (mismatches),
		.in_flight      (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		bit hold_served;
		hold_served = 1'b0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				rsp_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_cmd(tlpte_pkg::cmd_t c, logic [31:0] va, logic [31:0] fa,
		logic [11:0] fl);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid  <= 1'b1;
		command    <= c;
		virt_addr  <= va;
		frame_addr <= fa;
		page_flags <= fl;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	// mostly commands on a small set of pages so map, unmap and translate interact
	task automatic send_random();
		int              r;
		logic [31:0]     va;
		tlpte_pkg::cmd_t c;
		r = $urandom_range(99);
		if (r < 85) begin
			va = page_pool[$urandom_range(POOL_SIZE - 1)] | $urandom_range(4095);
			r  = $urandom_range(99);
			c  = (r < 35) ? tlpte_pkg::CMD_MAP : (r < 60) ? tlpte_pkg::CMD_UNMAP :
				(r < 97) ? tlpte_pkg::CMD_XLATE : tlpte_pkg::CMD_NOP;
		end else begin
			va = $urandom;
			c  = tlpte_pkg::cmd_t'($urandom_range(3));
		end
		send_cmd(c, va, $urandom, 12'($urandom_range(4095)));
	endtask

	initial begin
		logic [9:0] di;
		logic [9:0] ti;
		arst_n     <= 1'b0;
		cmd_valid  <= 1'b0;
		command    <= tlpte_pkg::CMD_NOP;
		virt_addr  <= '0;
		frame_addr <= '0;
		page_flags <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < POOL_SIZE; i++) begin
			di = (i < 16) ? 10'($urandom_range(3)) : 10'($urandom_range(DIR_ENTRIES - 1));
			ti = 10'($urandom_range(1023));
			page_pool[i] = {di, ti, 12'h000};
		end
		page_pool[0] = {10'(DIR_ENTRIES - 1), 10'h3FF, 12'h000};

		send_cmd(tlpte_pkg::CMD_XLATE, 32'h0000_0000, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_UNMAP, 32'h0000_0000, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_MAP,   32'h0000_0FFF, 32'hFFFF_FFFF, 12'hFFF);
		send_cmd(tlpte_pkg::CMD_MAP,   32'h0000_0000, 32'h1234_5000, 12'h001);
		send_cmd(tlpte_pkg::CMD_XLATE, 32'h0000_0ABC, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_XLATE, 32'h0000_0FFF, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_UNMAP, 32'h0000_0123, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_XLATE, 32'h0000_0000, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_UNMAP, 32'h0000_0000, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_MAP,   32'h0FFF_F000, 32'h0000_0000, 12'h000);
		send_cmd(tlpte_pkg::CMD_XLATE, 32'h0FFF_FFFF, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_MAP,   32'h1000_0000, 32'hFFFF_FFFF, 12'hFFF);
		send_cmd(tlpte_pkg::CMD_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_UNMAP, 32'hFFC0_0000, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_NOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
		send_cmd(tlpte_pkg::CMD_NOP,   32'h0000_0000, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_MAP,   32'h0040_0000, 32'h0BAD_F000, 12'h004);
		send_cmd(tlpte_pkg::CMD_MAP,   32'h0040_1000, 32'h1234_5678, 12'h000);
		send_cmd(tlpte_pkg::CMD_XLATE, 32'h0040_1FED, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_XLATE, 32'h0040_0800, 32'h0, 12'h000);
		send_cmd(tlpte_pkg::CMD_MAP,   32'h0000_0000, 32'hA5A5_A5A5, 12'h5A5);
		send_cmd(tlpte_pkg::CMD_XLATE, 32'h0000_0001, 32'h0, 12'h000);
		drain();

		// long receiver hold-off while commands keep coming
		hold_req = 1'b1;
		for (int i = 0; i < 24; i++)
			send_random();
		drain();

		for (int p = 0; p < 4; p++) begin
			tx_idle_pct  = phase_tx[p];
			rx_stall_pct = phase_rx[p];
			for (int i = 0; i < phase_len[p]; i++)
				send_random();
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/tlpte_pkg.sv
rtl/tlpte_store.sv
rtl/two_level_page_table_engine.sv
test/page_walk_checker.sv
test/tb_top.sv
